>>> rtl/core/bm3_pkg.sv
// Shared types, constants and helpers for the 3x3 binary morphology unit.
`default_nettype none

package bm3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_PASSES    = 1;

    localparam int DIM_W      = 11;
    localparam int ROW_W      = DIM_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] FRAME_DIM_RESET = DIM_W'(1024);

    localparam logic [7:0] WHITE_LEVEL = 8'd255;
    localparam logic [7:0] BLACK_LEVEL = 8'd0;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    // One beat between passes.
    typedef struct packed {
        logic flush;
        logic is_pixel;
        logic last;
        pix_t pix;
    } tok_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             restart;
    } geom_t;

    function automatic logic is_black(input pix_t p);
        return p.red == BLACK_LEVEL;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bm3_pixel_if.sv
// Input pixel channel: valid/ready handshake with kind and RGB payload.
`default_nettype none

interface bm3_pixel_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output kind, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input kind, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bm3_result_if.sv
// Result pixel channel: valid/ready handshake with RGB and end-of-frame flag.
`default_nettype none

interface bm3_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_frame;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output last_of_frame, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

>>> rtl/core/binary_morph_3x3_unit.sv
// Top level of the streaming 3x3 binary morphology unit (cascaded passes).
// Pipeline: a pass registers each accepted beat in A, then B, then its result register C,
// after each pass's window delay of frame_width + 1 beats.
// Throughput: one beat per cycle through every pass while the result side is ready.
// Reset: geometry 1024 x 1024 (width clamped to MAX_WIDTH), all passes idle;
// line stores are not cleared, border masking hides their contents.
`default_nettype none

module binary_morph_3x3_unit #(
    parameter int MAX_WIDTH = bm3_pkg::DEF_MAX_WIDTH,
    parameter int PASSES    = bm3_pkg::DEF_PASSES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bm3_pixel_if.sink                          pixel,
    bm3_result_if.source                       result,
    input  wire logic                          cfg_we,
    input  wire logic [bm3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bm3_pkg::CFG_DATA_W-1:0] cfg_data
);

    import bm3_pkg::*;

    localparam logic [DIM_W-1:0] WIDTH_RESET =
        (MAX_WIDTH < int'(FRAME_DIM_RESET)) ? DIM_W'(MAX_WIDTH) : FRAME_DIM_RESET;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] width_wr;
    logic [DIM_W-1:0] height_wr;
    geom_t            geom;

    logic [PASSES:0]  link_valid;
    logic [PASSES:0]  link_ready;
    tok_t             link_tok [PASSES+1];

    // clamp on write so passes see a usable geometry
    always_comb
    begin
        if (cfg_data == '0)
        begin
            width_wr = DIM_W'(1);
        end
        else if (int'(cfg_data) > MAX_WIDTH)
        begin
            width_wr = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            width_wr = cfg_data;
        end
        height_wr = (cfg_data == '0) ? DIM_W'(1) : cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= FRAME_DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= width_wr;
                REG_FRAME_HEIGHT: height_reg <= height_wr;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        geom.width   = width_reg;
        geom.height  = height_reg;
        geom.restart = cfg_we &&
                       (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
    end

    // input beat into the first pass: {flush, is_pixel, last, red, green, blue}
    assign link_valid[0] = pixel.valid;
    assign link_tok[0]   = {pixel.kind, !pixel.kind, 1'b0,
                            pixel.in_red, pixel.in_green, pixel.in_blue};
    assign pixel.ready   = link_ready[0];

    for (genvar p = 0; p < PASSES; p++)
    begin : g_pass
        bm3_stage #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .geom     (geom),
            .up_valid (link_valid[p]),
            .up_ready (link_ready[p]),
            .up_tok   (link_tok[p]),
            .dn_valid (link_valid[p+1]),
            .dn_ready (link_ready[p+1]),
            .dn_tok   (link_tok[p+1])
        );
    end

    // flush beats that left no pixel are dropped here
    assign result.valid         = link_valid[PASSES] && link_tok[PASSES].is_pixel;
    assign link_ready[PASSES]   = result.ready || !link_tok[PASSES].is_pixel;
    assign result.out_red       = link_tok[PASSES].pix.red;
    assign result.out_green     = link_tok[PASSES].pix.green;
    assign result.out_blue      = link_tok[PASSES].pix.blue;
    assign result.last_of_frame = link_tok[PASSES].last;

endmodule

`default_nettype wire

>>> rtl/core/bm3_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bm3_stage.sv
// One morphology pass: position counters, two-row line store, 3x3 window, result register.
`default_nettype none

module bm3_stage #(
    parameter int MAX_WIDTH = bm3_pkg::DEF_MAX_WIDTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bm3_pkg::geom_t geom,
    input  wire logic          up_valid,
    output      logic          up_ready,
    input  wire bm3_pkg::tok_t up_tok,
    output      logic          dn_valid,
    input  wire logic          dn_ready,
    output      bm3_pkg::tok_t dn_tok
);

    import bm3_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RAM_W = $bits(pix_t) + 1;

    typedef struct packed {
        logic          active;
        logic          produce;
        logic          top_ok;
        logic          bot_ok;
        logic          left_ok;
        logic          right_ok;
        logic          last;
        logic [AW-1:0] addr;
    } ctl_t;

    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [ROW_W-1:0] h_ext;
    logic             in_fill;
    logic             first_col;

    logic a_valid_reg;
    tok_t a_tok_reg;
    ctl_t a_ctl_reg;
    ctl_t a_ctl_next;
    logic b_valid_reg;
    tok_t b_tok_reg;
    ctl_t b_ctl_reg;
    logic c_valid_reg;
    tok_t c_tok_reg;
    tok_t c_tok_next;
    logic c_keep;

    logic a_load;
    logic a_adv;
    logic a_free;
    logic b_adv;
    logic b_free;
    logic c_ready;

    logic             byp_reg;
    logic [RAM_W-1:0] byp_data_reg;
    logic             ram_we;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_q;
    logic [RAM_W-1:0] line_word;

    logic [2:0] top_reg;
    logic [2:0] bot_reg;
    pix_t [2:0] mid_reg;
    logic       hit;

    // handshake
    assign c_ready  = !c_valid_reg || dn_ready;
    assign b_free   = !b_valid_reg || c_ready;
    assign b_adv    = b_valid_reg && c_ready;
    assign a_free   = !a_valid_reg || b_free;
    assign a_adv    = a_valid_reg && b_free;
    assign a_load   = up_valid && a_free;
    assign up_ready = a_free;
    assign dn_valid = c_valid_reg;
    assign dn_tok   = c_tok_reg;

    // position decode for the beat entering A
    assign h_ext     = ROW_W'(geom.height);
    assign in_fill   = row_reg < h_ext;
    assign first_col = col_reg == '0;

    always_comb
    begin
        a_ctl_next.active   = in_fill ? up_tok.is_pixel : 1'b1;
        a_ctl_next.produce  = a_ctl_next.active &&
                              (row_reg >= ROW_W'(2) || (row_reg == ROW_W'(1) && !first_col));
        a_ctl_next.top_ok   = first_col ? (row_reg >= ROW_W'(3)) : (row_reg >= ROW_W'(2));
        a_ctl_next.bot_ok   = first_col ? (row_reg <= h_ext) : in_fill;
        a_ctl_next.left_ok  = first_col ? (geom.width != DIM_W'(1)) : (col_reg >= DIM_W'(2));
        a_ctl_next.right_ok = !first_col;
        a_ctl_next.last     = first_col && (row_reg == h_ext + ROW_W'(1));
        a_ctl_next.addr     = AW'(col_reg);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (a_load && a_ctl_next.active)
        begin
            if (row_reg == h_ext + ROW_W'(1))
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == geom.width - DIM_W'(1))
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + DIM_W'(1);
            end
        end
    end

    // line store word: {black flag of row above-above, pixel of row above}
    assign line_word = byp_reg ? byp_data_reg : ram_q;
    assign ram_we    = a_adv && a_ctl_reg.active;
    assign ram_wdata = {is_black(pix_t'(line_word[$bits(pix_t)-1:0])), a_tok_reg.pix};

    bm3_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (a_ctl_reg.addr),
        .wdata (ram_wdata),
        .re    (a_load),
        .raddr (a_ctl_next.addr),
        .rdata (ram_q)
    );

    // window decision
    always_comb
    begin
        hit = (top_reg[0] && b_ctl_reg.top_ok && b_ctl_reg.left_ok)
            | (top_reg[1] && b_ctl_reg.top_ok)
            | (top_reg[2] && b_ctl_reg.top_ok && b_ctl_reg.right_ok)
            | (is_black(mid_reg[0]) && b_ctl_reg.left_ok)
            | (is_black(mid_reg[2]) && b_ctl_reg.right_ok)
            | (bot_reg[0] && b_ctl_reg.bot_ok && b_ctl_reg.left_ok)
            | (bot_reg[1] && b_ctl_reg.bot_ok)
            | (bot_reg[2] && b_ctl_reg.bot_ok && b_ctl_reg.right_ok);
        c_tok_next.flush    = b_tok_reg.flush;
        c_tok_next.is_pixel = b_ctl_reg.produce;
        c_tok_next.last     = b_ctl_reg.produce && b_ctl_reg.last;
        c_tok_next.pix      = (mid_reg[1].red == WHITE_LEVEL && hit) ? '0 : mid_reg[1];
        c_keep              = b_ctl_reg.produce || b_tok_reg.flush;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (a_free)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_adv && c_keep;
            end
            if (a_load)
            begin
                byp_reg <= ram_we && (a_ctl_reg.addr == a_ctl_next.addr);
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_tok_reg    <= up_tok;
            a_ctl_reg    <= a_ctl_next;
            byp_data_reg <= ram_wdata;
        end
        if (a_adv)
        begin
            b_tok_reg <= a_tok_reg;
            b_ctl_reg <= a_ctl_reg;
        end
        if (a_adv && a_ctl_reg.active)
        begin
            top_reg <= {line_word[RAM_W-1], top_reg[2:1]};
            mid_reg <= {pix_t'(line_word[$bits(pix_t)-1:0]), mid_reg[2:1]};
            bot_reg <= {is_black(a_tok_reg.pix), bot_reg[2:1]};
        end
        if (b_adv)
        begin
            c_tok_reg <= c_tok_next;
        end
    end

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_ext + ROW_W'(1))
        else $error("row counter past drain end");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < geom.width)
        else $error("column counter past frame width");

    a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && c_tok_reg.last |-> c_tok_reg.is_pixel)
        else $error("end of frame on a non-pixel beat");

    a_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_free |=> a_valid_reg && $stable(a_ctl_reg))
        else $error("stalled beat in A lost its position");

endmodule

`default_nettype wire
